@@ design/ps2_mouse_packet_decoder_assert.svh @@
// assertion macros for the ps2 mouse packet decoder
// no dependencies; taken in by the files that carry assertions
`ifndef PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PS2M_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define PS2M_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2M_ASSERT(lbl, clk, rst_n, prop, msg)
`define PS2M_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ design/ps2m_pkg.sv @@
// shared types and constants for the ps2 mouse packet decoder
// no dependencies
package ps2m_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] HDR_MASK  = 8'hC8;
  localparam logic [7:0] HDR_MATCH = 8'h08;
  localparam int         SIGN_X_BIT = 4;
  localparam int         SIGN_Y_BIT = 5;

  localparam logic [15:0] MAX_X_RESET = 16'd1024;
  localparam logic [15:0] MAX_Y_RESET = 16'd768;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WHEEL_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y      = 2'd2;

  typedef enum logic [2:0] {
    PH_UNSYNC,
    PH_HEADER,
    PH_X,
    PH_Y,
    PH_WHEEL
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic [7:0]        header;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y_down;
    logic signed [7:0] wheel_delta;
  } pkt_t;

endpackage

@@ design/ps2m_frame.sv @@
// packet framing state machine: sync on acknowledge, header check, byte capture
// depends on ps2m_pkg
module ps2m_frame
  import ps2m_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       wheel_mode_i,
  output pkt_t       pkt_o
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_byte_r, x_byte_nxt;
  logic [7:0] y_byte_r, y_byte_nxt;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    x_byte_nxt = x_byte_r;
    y_byte_nxt = y_byte_r;
    case (phase_r)
      PH_UNSYNC: begin
        if (byte_i == ACK_BYTE) phase_nxt = PH_HEADER;
      end
      PH_HEADER: begin
        if ((byte_i & HDR_MASK) == HDR_MATCH) begin
          header_nxt = byte_i;
          phase_nxt  = PH_X;
        end
      end
      PH_X: begin
        x_byte_nxt = byte_i;
        phase_nxt  = PH_Y;
      end
      PH_Y: begin
        y_byte_nxt = byte_i;
        phase_nxt  = wheel_mode_i ? PH_WHEEL : PH_HEADER;
      end
      PH_WHEEL: begin
        phase_nxt = PH_HEADER;
      end
      default: begin
        phase_nxt = PH_UNSYNC;
      end
    endcase
  end

  // packet outputs
  always_comb begin
    logic [7:0]        y_sel;
    logic signed [8:0] dy;
    y_sel = (phase_r == PH_Y) ? byte_i : y_byte_r;
    dy    = {header_r[SIGN_Y_BIT] && (y_sel != 8'd0), y_sel};
    pkt_o.header       = header_r;
    pkt_o.delta_x      = {header_r[SIGN_X_BIT] && (x_byte_r != 8'd0), x_byte_r};
    pkt_o.delta_y_down = 9'sd0 - dy;
    pkt_o.emit         = 1'b0;
    pkt_o.wheel_delta  = 8'sd0;
    case (phase_r)
      PH_Y: begin
        pkt_o.emit = !wheel_mode_i;
      end
      PH_WHEEL: begin
        pkt_o.emit        = 1'b1;
        pkt_o.wheel_delta = 8'd0 - byte_i;
      end
      default: begin
        pkt_o.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_UNSYNC;
      header_r <= 8'd0;
      x_byte_r <= 8'd0;
      y_byte_r <= 8'd0;
    end else if (step_i) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      x_byte_r <= x_byte_nxt;
      y_byte_r <= y_byte_nxt;
    end
  end

endmodule

@@ design/ps2m_pos_acc.sv @@
// absolute position accumulator with clamp to zero, screen limit and register range
// depends on ps2m_pkg
module ps2m_pos_acc
  import ps2m_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_i,
  input  logic signed [8:0]        delta_i,
  input  logic [15:0]              limit_i,
  output logic [POSITION_BITS-1:0] pos_nxt_o
);

  localparam int CW = POSITION_BITS + 18;

  logic [POSITION_BITS-1:0] pos_r;
  logic signed [CW-1:0]     sum;
  logic [CW-1:0]            clamp;
  logic [CW-1:0]            lim_ext;
  logic [CW-1:0]            pmax_ext;

  assign lim_ext  = CW'(limit_i);
  assign pmax_ext = CW'({POSITION_BITS{1'b1}});
  assign sum      = $signed(CW'(pos_r)) + CW'(delta_i);

  always_comb begin
    clamp = sum[CW-1] ? '0 : sum;
    if (clamp > lim_ext)  clamp = lim_ext;
    if (clamp > pmax_ext) clamp = pmax_ext;
  end

  assign pos_nxt_o = clamp[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step_i) begin
      pos_r <= pos_nxt_o;
    end
  end

endmodule

@@ design/ps2_mouse_packet_decoder.sv @@
// top level of the ps2 mouse packet decoder: input register, framing, positions, result register
// depends on ps2m_pkg, ps2m_frame, ps2m_pos_acc and ps2_mouse_packet_decoder_assert.svh
//
// usage:
//   in_valid/in_stall carry one received mouse byte per transfer on in_rx_byte.
//   out_valid/out_stall carry one decoded packet per transfer: header flags,
//   signed dx, downward dy, negated wheel and the clamped absolute position.
//   cfg_valid/cfg_ready write wheel mode (index 0), x limit (1) and y limit (2);
//   cfg_ready is always high, other indexes are ignored. write only when idle.
// timing:
//   a byte is registered on transfer and decoded from the input register; the packet
//   result is loaded into the output register when its last byte leaves the input register.
//   one byte per cycle is accepted while in_stall is low; the single decode stage between input
//   and output register sets that rate.
// reset:
//   synchronous active-low reset empties both registers, returns framing to
//   waiting for the acknowledge byte and clears the positions.
// stall:
//   while out_stall holds a result, bytes that finish no packet still pass;
//   a byte that would finish one waits in the input register and in_stall rises.
`include "ps2_mouse_packet_decoder_assert.svh"
module ps2_mouse_packet_decoder
  import ps2m_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_button_flags,
  output logic signed [8:0]       out_delta_x,
  output logic signed [8:0]       out_delta_y_down,
  output logic signed [7:0]       out_wheel_delta,
  output logic [15:0]             out_abs_x,
  output logic [15:0]             out_abs_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data
);

  logic        wheel_mode_r;
  logic [15:0] max_x_r;
  logic [15:0] max_y_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  logic              out_valid_r;
  logic [7:0]        flags_r;
  logic signed [8:0] dx_r;
  logic signed [8:0] dy_r;
  logic signed [7:0] wheel_r;
  logic [15:0]       abs_x_r;
  logic [15:0]       abs_y_r;

  pkt_t                     pkt;
  logic                     out_free;
  logic                     advance;
  logic                     emit_step;
  logic [POSITION_BITS-1:0] pos_x_nxt;
  logic [POSITION_BITS-1:0] pos_y_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      max_x_r      <= MAX_X_RESET;
      max_y_r      <= MAX_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WHEEL_MODE: wheel_mode_r <= cfg_data[0];
        CFG_MAX_X:      max_x_r      <= cfg_data;
        CFG_MAX_Y:      max_y_r      <= cfg_data;
        default:        wheel_mode_r <= wheel_mode_r;
      endcase
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && (!pkt.emit || out_free);
  assign emit_step = advance && pkt.emit;
  assign in_stall  = s1_valid_r && !advance;

  ps2m_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (advance),
    .byte_i       (s1_byte_r),
    .wheel_mode_i (wheel_mode_r),
    .pkt_o        (pkt)
  );

  ps2m_pos_acc #(.POSITION_BITS(POSITION_BITS)) u_pos_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (emit_step),
    .delta_i   (pkt.delta_x),
    .limit_i   (max_x_r),
    .pos_nxt_o (pos_x_nxt)
  );

  ps2m_pos_acc #(.POSITION_BITS(POSITION_BITS)) u_pos_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (emit_step),
    .delta_i   (pkt.delta_y_down),
    .limit_i   (max_y_r),
    .pos_nxt_o (pos_y_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_step) begin
      flags_r <= pkt.header;
      dx_r    <= pkt.delta_x;
      dy_r    <= pkt.delta_y_down;
      wheel_r <= pkt.wheel_delta;
      abs_x_r <= 16'(pos_x_nxt);
      abs_y_r <= 16'(pos_y_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_flags = flags_r;
  assign out_delta_x      = dx_r;
  assign out_delta_y_down = dy_r;
  assign out_wheel_delta  = wheel_r;
  assign out_abs_x        = abs_x_r;
  assign out_abs_y        = abs_y_r;

  `PS2M_ASSERT(a_emit_loads_out, clk, rst_n, emit_step |=> out_valid_r, "packet lost on emit")
  `PS2M_ASSERT(a_held_result_kept, clk, rst_n, (out_valid_r && out_stall && !emit_step) |=> (out_valid_r && $stable(flags_r) && $stable(abs_x_r)), "stalled result changed")
  `PS2M_ASSERT(a_no_overwrite, clk, rst_n, emit_step |-> (!out_valid_r || !out_stall), "result overwritten while stalled")
  `PS2M_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !s1_valid_r), "registers not empty after reset")

endmodule
